// ===== sv/apu_pkg.sv =====
// shared types, constants and lookup functions for the audio unit
`timescale 1ns / 1ps
`default_nettype none
package apu_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_BYTE  = 2'd3
    } t_cmd;

    localparam logic [4:0] REG_TRI_CTL    = 5'h08;
    localparam logic [4:0] REG_TRI_LO     = 5'h0A;
    localparam logic [4:0] REG_TRI_HI     = 5'h0B;
    localparam logic [4:0] REG_NOISE_CTL  = 5'h0C;
    localparam logic [4:0] REG_NOISE_MODE = 5'h0E;
    localparam logic [4:0] REG_NOISE_LEN  = 5'h0F;
    localparam logic [4:0] REG_DMC_CTL    = 5'h10;
    localparam logic [4:0] REG_DMC_LOAD   = 5'h11;
    localparam logic [4:0] REG_DMC_ADDR   = 5'h12;
    localparam logic [4:0] REG_DMC_LEN    = 5'h13;
    localparam logic [4:0] REG_STATUS     = 5'h15;
    localparam logic [4:0] REG_FRAME      = 5'h17;

    localparam logic [1:0] PULSE_CTL   = 2'd0;
    localparam logic [1:0] PULSE_SWEEP = 2'd1;
    localparam logic [1:0] PULSE_LO    = 2'd2;
    localparam logic [1:0] PULSE_HI    = 2'd3;

    localparam logic [11:0] FRAME_LAST   = 12'd3729;
    localparam logic [10:0] PERIOD_MASK  = 11'h7FF;
    localparam logic [15:0] DMC_BASE     = 16'hC000;
    localparam logic [15:0] ADDR_TOP     = 16'h8000;

    typedef struct packed {
        logic       tick;
        logic       quarter;
        logic       half;
        logic       wr;
        logic [1:0] wr_sel;
        logic [7:0] wr_data;
        logic       len_en;
        logic       len_clr;
    } t_pulse_ctl;

    function automatic logic [7:0] len_lookup(input logic [4:0] idx);
        logic [7:0] v;
        begin
            case (idx)
                5'd0: v = 8'd10;    5'd1: v = 8'd254;  5'd2: v = 8'd20;   5'd3: v = 8'd2;
                5'd4: v = 8'd40;    5'd5: v = 8'd4;    5'd6: v = 8'd80;   5'd7: v = 8'd6;
                5'd8: v = 8'd160;   5'd9: v = 8'd8;    5'd10: v = 8'd60;  5'd11: v = 8'd10;
                5'd12: v = 8'd14;   5'd13: v = 8'd12;  5'd14: v = 8'd26;  5'd15: v = 8'd14;
                5'd16: v = 8'd12;   5'd17: v = 8'd16;  5'd18: v = 8'd24;  5'd19: v = 8'd18;
                5'd20: v = 8'd48;   5'd21: v = 8'd20;  5'd22: v = 8'd96;  5'd23: v = 8'd22;
                5'd24: v = 8'd192;  5'd25: v = 8'd24;  5'd26: v = 8'd72;  5'd27: v = 8'd26;
                5'd28: v = 8'd16;   5'd29: v = 8'd28;  5'd30: v = 8'd32;  5'd31: v = 8'd30;
                default: v = 8'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [10:0] noise_lookup(input logic [3:0] idx);
        logic [10:0] v;
        begin
            case (idx)
                4'd0: v = 11'd2;     4'd1: v = 11'd4;     4'd2: v = 11'd8;     4'd3: v = 11'd16;
                4'd4: v = 11'd32;    4'd5: v = 11'd48;    4'd6: v = 11'd64;    4'd7: v = 11'd80;
                4'd8: v = 11'd101;   4'd9: v = 11'd127;   4'd10: v = 11'd190;  4'd11: v = 11'd254;
                4'd12: v = 11'd381;  4'd13: v = 11'd508;  4'd14: v = 11'd1017;
                4'd15: v = 11'd2034;
                default: v = 11'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] dmc_lookup(input logic [3:0] idx);
        logic [7:0] v;
        begin
            case (idx)
                4'd0: v = 8'd214;  4'd1: v = 8'd190;  4'd2: v = 8'd170;  4'd3: v = 8'd160;
                4'd4: v = 8'd143;  4'd5: v = 8'd127;  4'd6: v = 8'd113;  4'd7: v = 8'd107;
                4'd8: v = 8'd95;   4'd9: v = 8'd80;   4'd10: v = 8'd71;  4'd11: v = 8'd64;
                4'd12: v = 8'd53;  4'd13: v = 8'd42;  4'd14: v = 8'd36;  4'd15: v = 8'd27;
                default: v = 8'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] duty_lookup(input logic [1:0] idx);
        logic [7:0] v;
        begin
            case (idx)
                2'd0: v = 8'h40;
                2'd1: v = 8'h60;
                2'd2: v = 8'h78;
                2'd3: v = 8'h9F;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

    // envelope step, result is {divider, volume}
    function automatic logic [7:0] env_step(input logic [7:0] ctl, input logic [3:0] div,
                                            input logic [3:0] vol);
        logic [3:0] d;
        logic [3:0] v;
        begin
            d = div;
            v = vol;
            if (div == 4'd0) begin
                d = ctl[3:0];
                if (vol == 4'd0 && ctl[5]) begin
                    v = 4'd15;
                end else if (vol != 4'd0) begin
                    v = vol - 4'd1;
                end
            end else begin
                d = div - 4'd1;
            end
            return {d, v};
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/apu_pulse.sv =====
// one pulse channel with envelope, sweep, length counter and sequencer
`timescale 1ns / 1ps
`default_nettype none
module apu_pulse
    import apu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_pulse_ctl i_ctl,
    input  wire logic       i_chan_two,
    output logic [3:0]      o_level,
    output logic            o_len_nz
);

    logic [10:0] r_period, n_period;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_sweep, n_sweep;
    logic        r_reload, n_reload;
    logic [7:0]  r_ctl, n_ctl;
    logic [2:0]  r_sdiv, n_sdiv;
    logic [2:0]  r_step, n_step;
    logic [10:0] r_div, n_div;
    logic [3:0]  r_ediv, n_ediv;
    logic [3:0]  r_vol, n_vol;
    logic [3:0]  r_out, n_out;
    logic [11:0] sw_tgt, tk_tgt;
    logic [7:0]  env;
    logic [7:0]  duty;

    function automatic logic [11:0] target(input logic [10:0] per, input logic [7:0] sw,
                                           input logic two);
        logic [10:0] chg;
        logic [11:0] t;
        begin
            chg = per >> sw[2:0];
            if (sw[3]) begin
                t = two ? {1'b0, per - chg} : {1'b0, per + ~chg};
            end else begin
                t = {1'b0, per} + {1'b0, chg};
            end
            return t;
        end
    endfunction

    always_comb begin
        n_period = r_period;
        n_len    = r_len;
        n_sweep  = r_sweep;
        n_reload = r_reload;
        n_ctl    = r_ctl;
        n_sdiv   = r_sdiv;
        n_step   = r_step;
        n_div    = r_div;
        n_ediv   = r_ediv;
        n_vol    = r_vol;
        n_out    = r_out;
        sw_tgt   = target(r_period, r_sweep, i_chan_two);
        env      = env_step(r_ctl, r_ediv, r_vol);
        duty     = duty_lookup(r_ctl[7:6]);

        if (i_ctl.wr) begin
            case (i_ctl.wr_sel)
                PULSE_CTL: begin
                    n_ctl = i_ctl.wr_data;
                end
                PULSE_SWEEP: begin
                    n_sweep  = i_ctl.wr_data;
                    n_reload = 1'b1;
                end
                PULSE_LO: begin
                    n_period = {r_period[10:8], i_ctl.wr_data};
                end
                PULSE_HI: begin
                    if (i_ctl.len_en) begin
                        n_len = len_lookup(i_ctl.wr_data[7:3]);
                    end
                    n_period = {i_ctl.wr_data[2:0], r_period[7:0]};
                    n_step   = 3'd0;
                    n_ediv   = r_ctl[3:0];
                    n_vol    = 4'd15;
                end
                default: begin
                end
            endcase
        end
        if (i_ctl.len_clr) begin
            n_len = 8'd0;
        end
        if (i_ctl.quarter) begin
            n_ediv = env[7:4];
            n_vol  = env[3:0];
        end
        if (i_ctl.half) begin
            if (r_len != 8'd0 && !r_ctl[5]) begin
                n_len = r_len - 8'd1;
            end
            if (r_sdiv == 3'd0 && r_sweep[7] && r_period >= 11'd8 && n_len != 8'd0
                && sw_tgt <= {1'b0, PERIOD_MASK} && r_sweep[2:0] != 3'd0) begin
                n_period = sw_tgt[10:0];
            end
            if (r_sdiv == 3'd0 || r_reload) begin
                n_reload = 1'b0;
                n_sdiv   = r_sweep[6:4];
            end else begin
                n_sdiv = r_sdiv - 3'd1;
            end
        end
        tk_tgt = target(n_period, r_sweep, i_chan_two);
        if (i_ctl.tick) begin
            if (duty[3'd7 - r_step] && n_len != 8'd0 && n_period >= 11'd8
                && tk_tgt <= {1'b0, PERIOD_MASK}) begin
                n_out = r_ctl[4] ? r_ctl[3:0] : n_vol;
            end else begin
                n_out = 4'd0;
            end
            if (r_div != 11'd0) begin
                n_div = r_div - 11'd1;
            end else begin
                n_div  = n_period;
                n_step = r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_len    <= '0;
            r_sweep  <= '0;
            r_reload <= 1'b0;
            r_ctl    <= '0;
            r_sdiv   <= '0;
            r_step   <= '0;
            r_div    <= '0;
            r_ediv   <= '0;
            r_vol    <= '0;
            r_out    <= '0;
        end else begin
            r_period <= n_period;
            r_len    <= n_len;
            r_sweep  <= n_sweep;
            r_reload <= n_reload;
            r_ctl    <= n_ctl;
            r_sdiv   <= n_sdiv;
            r_step   <= n_step;
            r_div    <= n_div;
            r_ediv   <= n_ediv;
            r_vol    <= n_vol;
            r_out    <= n_out;
        end
    end

    assign o_level  = r_out;
    assign o_len_nz = (r_len != 8'd0);

endmodule
`default_nettype wire

// ===== sv/nes_audio_unit.sv =====
// top level of the audio unit: frame sequencer, triangle, noise, delta channel and stream ports
`timescale 1ns / 1ps
`default_nettype none
// Takes one item per clock: a tick, a register write, a status read or a sample byte, each
// giving exactly one result with the channel levels and irq state after that item. All
// channel state is updated in the cycle the item is accepted; the state registers together
// with the read-data register form the result stage, so the output shows a result in the
// cycle after its transfer and a new item is taken whenever the result slot is empty or being
// drained. Sustained rate is one item per cycle while m_axis_tready is high; when fetch_request
// is high the next sample byte must be sent as a byte item, ticks may come in between.
module nes_audio_unit
    import apu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // reg_offset, write_value, fetched_byte
    input  wire logic [1:0]  s_axis_tuser,  // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data, irq_active, pulse_one_level, pulse_two_level, triangle_level,
    // noise_level, delta_level, fetch_request, fetch_address
    output logic [55:0]      m_axis_tdata
);

    logic       acc;
    t_cmd       cmd;
    logic [4:0] off;
    logic [7:0] wv, fb;
    logic       odd_tick, any_tick, wr, rd15, byte_in, wr17, quarter, half, fa, five;

    logic        r_valid;
    logic [7:0]  r_rd, n_rd;
    logic        r_odd, n_odd;
    logic [7:0]  r_en, n_en;
    logic [7:0]  r_mode, n_mode;
    logic        r_firq, n_firq;
    logic        r_dirq, n_dirq;
    logic [11:0] r_fc, n_fc;
    logic [2:0]  r_fs, n_fs;

    logic [10:0] r_tper, n_tper;
    logic [7:0]  r_tlen, n_tlen;
    logic [7:0]  r_tctl, n_tctl;
    logic        r_treload, n_treload;
    logic [10:0] r_tdiv, n_tdiv;
    logic [6:0]  r_tlin, n_tlin;
    logic [4:0]  r_tstep, n_tstep;
    logic [3:0]  r_tout, n_tout;

    logic [7:0]  r_nmode, n_nmode;
    logic [7:0]  r_nlen, n_nlen;
    logic [7:0]  r_nctl, n_nctl;
    logic [14:0] r_lfsr, n_lfsr;
    logic [10:0] r_nper, n_nper;
    logic [10:0] r_ndiv, n_ndiv;
    logic [3:0]  r_nediv, n_nediv;
    logic [3:0]  r_nvol, n_nvol;
    logic [3:0]  r_nout, n_nout;
    logic [7:0]  nenv;
    logic        fbit;

    logic [1:0]  r_dflags, n_dflags;
    logic [3:0]  r_drate, n_drate;
    logic [6:0]  r_dout, n_dout;
    logic [15:0] r_dstart, n_dstart;
    logic [11:0] r_dlen, n_dlen;
    logic [15:0] r_daddr, n_daddr;
    logic [11:0] r_dbytes, n_dbytes;
    logic [2:0]  r_dbits, n_dbits;
    logic [7:0]  r_dbuf, n_dbuf;
    logic        r_dsil, n_dsil;
    logic [7:0]  r_ddiv, n_ddiv;
    logic        r_dpend, n_dpend;
    logic        dfinish;

    t_pulse_ctl p1_ctl, p2_ctl;
    logic [3:0] p1_level, p2_level;
    logic       p1_nz, p2_nz;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign cmd      = t_cmd'(s_axis_tuser);
    assign off      = s_axis_tdata[4:0];
    assign wv       = s_axis_tdata[12:5];
    assign fb       = s_axis_tdata[20:13];
    assign any_tick = acc && cmd == CMD_TICK;
    assign odd_tick = any_tick && r_odd;
    assign wr       = acc && cmd == CMD_WRITE;
    assign rd15     = acc && cmd == CMD_READ && off == REG_STATUS;
    assign byte_in  = acc && cmd == CMD_BYTE && r_dpend;
    assign wr17     = wr && off == REG_FRAME;
    assign five     = r_mode[7];

    // frame sequencer
    always_comb begin
        n_odd  = r_odd;
        n_fc   = r_fc;
        n_fs   = r_fs;
        n_mode = r_mode;
        n_firq = r_firq;
        if (any_tick) begin
            n_odd = !r_odd;
        end
        if (odd_tick) begin
            n_fc = r_fc + 12'd1;
            if (n_fc > FRAME_LAST) begin
                n_fc = 12'd0;
                n_fs = r_fs + 3'd1;
                if (n_fs >= 3'd5 || (n_fs >= 3'd4 && !five)) begin
                    n_fs = 3'd0;
                end
            end
        end
        fa      = odd_tick && n_fc == 12'd0;
        quarter = (fa && !(n_fs == 3'd3 && five)) || (wr17 && wv[7]);
        half    = (fa && (n_fs == 3'd1 || (n_fs == 3'd3 && !five) || (n_fs == 3'd4 && five)))
                  || (wr17 && wv[7]);
        if (fa && n_fs == 3'd3 && r_mode[7:6] == 2'd0) begin
            n_firq = 1'b1;
        end
        if (wr17) begin
            n_mode = wv;
            n_fc   = 12'd0;
            n_fs   = 3'd0;
            if (wv[6]) begin
                n_firq = 1'b0;
            end
        end
        if (rd15) begin
            n_firq = 1'b0;
        end
    end

    // pulse channel controls
    always_comb begin
        p1_ctl         = '0;
        p1_ctl.tick    = odd_tick;
        p1_ctl.quarter = quarter;
        p1_ctl.half    = half;
        p1_ctl.wr      = wr && off[4:2] == 3'd0;
        p1_ctl.wr_sel  = off[1:0];
        p1_ctl.wr_data = wv;
        p1_ctl.len_en  = r_en[0];
        p1_ctl.len_clr = wr && off == REG_STATUS && !wv[0];
        p2_ctl         = p1_ctl;
        p2_ctl.wr      = wr && off[4:2] == 3'd1;
        p2_ctl.len_en  = r_en[1];
        p2_ctl.len_clr = wr && off == REG_STATUS && !wv[1];
    end

    apu_pulse u_pulse1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (p1_ctl),
        .i_chan_two (1'b0),
        .o_level    (p1_level),
        .o_len_nz   (p1_nz)
    );

    apu_pulse u_pulse2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (p2_ctl),
        .i_chan_two (1'b1),
        .o_level    (p2_level),
        .o_len_nz   (p2_nz)
    );

    // triangle, noise, delta channel, status
    always_comb begin
        n_tper = r_tper;  n_tlen = r_tlen;  n_tctl = r_tctl;  n_treload = r_treload;
        n_tdiv = r_tdiv;  n_tlin = r_tlin;  n_tstep = r_tstep;  n_tout = r_tout;
        n_nmode = r_nmode;  n_nlen = r_nlen;  n_nctl = r_nctl;  n_lfsr = r_lfsr;
        n_nper = r_nper;  n_ndiv = r_ndiv;  n_nediv = r_nediv;  n_nvol = r_nvol;
        n_nout = r_nout;
        n_dflags = r_dflags;  n_drate = r_drate;  n_dout = r_dout;  n_dstart = r_dstart;
        n_dlen = r_dlen;  n_daddr = r_daddr;  n_dbytes = r_dbytes;  n_dbits = r_dbits;
        n_dbuf = r_dbuf;  n_dsil = r_dsil;  n_ddiv = r_ddiv;  n_dpend = r_dpend;
        n_en = r_en;  n_dirq = r_dirq;  n_rd = 8'd0;
        nenv    = env_step(r_nctl, r_nediv, r_nvol);
        fbit    = r_lfsr[0] ^ (r_nmode[7] ? r_lfsr[6] : r_lfsr[1]);
        dfinish = 1'b0;

        if (wr) begin
            case (off)
                REG_TRI_CTL: n_tctl = wv;
                REG_TRI_LO: n_tper = {r_tper[10:8], wv};
                REG_TRI_HI: begin
                    if (r_en[2]) begin
                        n_tlen = len_lookup(wv[7:3]);
                    end
                    n_tper    = {wv[2:0], r_tper[7:0]};
                    n_treload = 1'b1;
                end
                REG_NOISE_CTL: n_nctl = wv;
                REG_NOISE_MODE: begin
                    n_nmode = wv;
                    n_nper  = noise_lookup(wv[3:0]);
                end
                REG_NOISE_LEN: begin
                    if (r_en[3]) begin
                        n_nlen = len_lookup(wv[7:3]);
                    end
                    n_nediv = r_nctl[3:0];
                    n_nvol  = 4'd15;
                end
                REG_DMC_CTL: begin
                    n_dflags = wv[7:6];
                    n_drate  = wv[3:0];
                    n_ddiv   = 8'd0;
                end
                REG_DMC_LOAD: n_dout = wv[6:0];
                REG_DMC_ADDR: begin
                    n_dstart = DMC_BASE | {2'b00, wv, 6'd0};
                    n_daddr  = DMC_BASE | {2'b00, wv, 6'd0};
                end
                REG_DMC_LEN: begin
                    n_dlen   = {wv, 4'd1};
                    n_dbytes = {wv, 4'd1};
                end
                REG_STATUS: begin
                    n_en = wv;
                    if (!wv[3]) n_nlen = 8'd0;
                    if (!wv[2]) n_tlen = 8'd0;
                    if (!wv[4]) begin
                        n_dbytes = 12'd0;
                    end else if (r_dbytes == 12'd0) begin
                        n_daddr  = r_dstart;
                        n_dbytes = r_dlen;
                    end
                    n_dirq = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (rd15) begin
            n_rd = {r_dirq, r_firq, 1'b0, r_dbytes != 12'd0, r_nlen != 8'd0,
                    r_tlen != 8'd0, p2_nz, p1_nz};
        end

        if (quarter) begin
            if (r_treload) begin
                n_tlin = r_tctl[6:0];
            end else if (r_tlin != 7'd0) begin
                n_tlin = r_tlin - 7'd1;
            end
            if (!r_tctl[7]) begin
                n_treload = 1'b0;
            end
            n_nediv = nenv[7:4];
            n_nvol  = nenv[3:0];
        end
        if (half) begin
            if (r_tlen != 8'd0 && !r_tctl[7]) n_tlen = r_tlen - 8'd1;
            if (r_nlen != 8'd0 && !r_nctl[5]) n_nlen = r_nlen - 8'd1;
        end

        if (any_tick) begin
            n_tout = (r_tper > 11'd1) ? (r_tstep[4] ? r_tstep[3:0] : ~r_tstep[3:0]) : 4'd0;
            if (r_tdiv != 11'd0) begin
                n_tdiv = r_tdiv - 11'd1;
            end else begin
                n_tdiv = r_tper;
                if (n_tlin != 7'd0 && n_tlen != 8'd0) begin
                    n_tstep = r_tstep + 5'd1;
                end
            end
        end

        if (odd_tick) begin
            if (n_nlen != 8'd0 && !r_lfsr[0]) begin
                n_nout = r_nctl[4] ? r_nctl[3:0] : n_nvol;
            end else begin
                n_nout = 4'd0;
            end
            if (r_ndiv != 11'd0) begin
                n_ndiv = r_ndiv - 11'd1;
            end else begin
                n_ndiv = r_nper;
                n_lfsr = {fbit, r_lfsr[14:1]};
            end
            if (!r_dpend) begin
                if (r_ddiv >= dmc_lookup(r_drate)) begin
                    n_ddiv = 8'd0;
                    if (r_dbits == 3'd0 && r_dbytes != 12'd0) begin
                        n_dpend = 1'b1;
                    end else begin
                        if (r_dbits == 3'd0) begin
                            n_dsil = 1'b1;
                        end
                        dfinish = 1'b1;
                    end
                end else begin
                    n_ddiv = r_ddiv + 8'd1;
                end
            end
        end

        if (byte_in) begin
            n_dpend = 1'b0;
            n_dbuf  = fb;
            n_daddr = (r_daddr + 16'd1) | ADDR_TOP;
            if (r_dbytes != 12'd0) begin
                n_dbytes = r_dbytes - 12'd1;
            end
            n_dsil = 1'b0;
            if (n_dbytes == 12'd0 && r_dflags[0]) begin
                n_daddr  = r_dstart;
                n_dbytes = r_dlen;
            end else if (n_dbytes == 12'd0 && r_dflags[1]) begin
                n_dirq = 1'b1;
            end
            dfinish = 1'b1;
        end

        if (dfinish) begin
            n_dbits = r_dbits - 3'd1;
            if (!n_dsil) begin
                if (n_dbuf[0] && r_dout <= 7'd125) begin
                    n_dout = r_dout + 7'd2;
                end else if (!n_dbuf[0] && r_dout >= 7'd2) begin
                    n_dout = r_dout - 7'd2;
                end
            end
            n_dbuf = n_dbuf >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (acc) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;  r_odd <= 1'b0;  r_en <= '0;  r_mode <= '0;  r_firq <= 1'b0;
            r_dirq <= 1'b0;  r_fc <= '0;  r_fs <= '0;
            r_tper <= '0;  r_tlen <= '0;  r_tctl <= '0;  r_treload <= 1'b0;  r_tdiv <= '0;
            r_tlin <= '0;  r_tstep <= '0;  r_tout <= '0;
            r_nmode <= '0;  r_nlen <= '0;  r_nctl <= '0;  r_lfsr <= 15'd1;  r_nper <= '0;
            r_ndiv <= '0;  r_nediv <= '0;  r_nvol <= '0;  r_nout <= '0;
            r_dflags <= '0;  r_drate <= '0;  r_dout <= '0;  r_dstart <= '0;  r_dlen <= '0;
            r_daddr <= '0;  r_dbytes <= '0;  r_dbits <= '0;  r_dbuf <= '0;  r_dsil <= 1'b0;
            r_ddiv <= '0;  r_dpend <= 1'b0;
        end else if (acc) begin
            r_rd <= n_rd;  r_odd <= n_odd;  r_en <= n_en;  r_mode <= n_mode;
            r_firq <= n_firq;  r_dirq <= n_dirq;  r_fc <= n_fc;  r_fs <= n_fs;
            r_tper <= n_tper;  r_tlen <= n_tlen;  r_tctl <= n_tctl;  r_treload <= n_treload;
            r_tdiv <= n_tdiv;  r_tlin <= n_tlin;  r_tstep <= n_tstep;  r_tout <= n_tout;
            r_nmode <= n_nmode;  r_nlen <= n_nlen;  r_nctl <= n_nctl;  r_lfsr <= n_lfsr;
            r_nper <= n_nper;  r_ndiv <= n_ndiv;  r_nediv <= n_nediv;  r_nvol <= n_nvol;
            r_nout <= n_nout;
            r_dflags <= n_dflags;  r_drate <= n_drate;  r_dout <= n_dout;
            r_dstart <= n_dstart;  r_dlen <= n_dlen;  r_daddr <= n_daddr;
            r_dbytes <= n_dbytes;  r_dbits <= n_dbits;  r_dbuf <= n_dbuf;
            r_dsil <= n_dsil;  r_ddiv <= n_ddiv;  r_dpend <= n_dpend;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r_daddr | ADDR_TOP, r_dpend, r_dout, r_nout, r_tout,
                            p2_level, p1_level, r_firq | r_dirq, r_rd};

    a_addr_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[48])
        else $error("fetch address lost its top bit");

    a_dmc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (odd_tick && r_dpend) |=> $stable(r_ddiv))
        else $error("delta divider moved while a byte was awaited");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !rd15) |=> (r_rd == 8'd0))
        else $error("read data set on a transfer that was not a status read");

    a_firq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd15 |=> !r_firq)
        else $error("frame irq survived a status read");

endmodule
`default_nettype wire
